### design/mld_pkg.sv
// Shared types, register indexes, reset values and the letter table
// for the Morse letter decoder. No dependencies.
package mld_pkg;

    localparam int DUR_W = 16;
    localparam int SUM_W = 10;
    localparam int POS_W = 4;
    localparam int LETTER_W = 7;
    localparam int CFG_IDX_W = 8;

    localparam logic [SUM_W-1:0] SUM_MAX = 10'd1023;
    localparam logic [POS_W-1:0] POS_MAX = 4'd15;
    localparam logic [3:0] DOT_WEIGHT = 4'd3;
    localparam logic [3:0] DASH_WEIGHT = 4'd10;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PULSE_MIN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPLIT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PULSE_MAX = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LETTER_GAP = 8'd3;

    localparam logic [DUR_W-1:0] PULSE_MIN_RST = 16'd30;
    localparam logic [DUR_W-1:0] SPLIT_RST = 16'd400;
    localparam logic [DUR_W-1:0] PULSE_MAX_RST = 16'd800;
    localparam logic [DUR_W-1:0] LETTER_GAP_RST = 16'd800;

    localparam logic OP_PRESS = 1'b0;
    localparam logic OP_IDLE = 1'b1;

    localparam logic [LETTER_W-1:0] LETTER_NONE = 7'd0;

    typedef struct packed {
        logic [DUR_W-1:0] pulse_min_ms;
        logic [DUR_W-1:0] dot_dash_split_ms;
        logic [DUR_W-1:0] pulse_max_ms;
        logic [DUR_W-1:0] letter_gap_ms;
    } t_cfg;

    typedef struct packed {
        logic                valid;
        logic [LETTER_W-1:0] letter;
    } t_result;

    // Sum of weight * position to ASCII capital; LETTER_NONE if unknown.
    function automatic logic [LETTER_W-1:0] lookup_letter(
        input logic [SUM_W-1:0] sum,
        input logic             dot_first
    );
        logic [LETTER_W-1:0] ch;
        unique case (sum)
            10'd3:   ch = 7'h45;                         // E
            10'd9:   ch = 7'h49;                         // I
            10'd10:  ch = 7'h54;                         // T
            10'd16:  ch = 7'h4E;                         // N
            10'd18:  ch = 7'h53;                         // S
            10'd23:  ch = 7'h41;                         // A
            10'd25:  ch = 7'h44;                         // D
            10'd30:  ch = dot_first ? 7'h48 : 7'h4D;     // H / M
            10'd32:  ch = 7'h52;                         // R
            10'd37:  ch = 7'h42;                         // B
            10'd39:  ch = dot_first ? 7'h55 : 7'h47;     // U / G
            10'd44:  ch = 7'h4C;                         // L
            10'd46:  ch = 7'h4B;                         // K
            10'd51:  ch = dot_first ? 7'h46 : 7'h5A;     // F / Z
            10'd53:  ch = 7'h57;                         // W
            10'd58:  ch = dot_first ? 7'h56 : 7'h43;     // V / C
            10'd60:  ch = 7'h4F;                         // O
            10'd65:  ch = dot_first ? 7'h50 : 7'h58;     // P / X
            10'd79:  ch = 7'h51;                         // Q
            10'd86:  ch = 7'h59;                         // Y
            10'd93:  ch = 7'h4A;                         // J
            default: ch = LETTER_NONE;
        endcase
        return ch;
    endfunction

endpackage

### design/morse_letter_decoder_top.sv
// Morse letter decoder top level: config registers, input and result registers.
// Depends on mld_pkg and mld_core.
//
// One event beat (key press length or idle time, in ms) is accepted every clock
// cycle while o_in_stall is low. A beat is held in the input register, where it is
// classified and folded into the running sum; a letter ending there is registered
// in the result register when the stage advances.
// Only a held result with downstream stall can hold up the input side.
// Config writes are always ready and must be made while no beat is in flight.
module morse_letter_decoder_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_op,
    input  logic [mld_pkg::DUR_W-1:0]       i_duration_ms,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [mld_pkg::LETTER_W-1:0]    o_letter,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mld_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mld_pkg::DUR_W-1:0]       i_cfg_data
);
    import mld_pkg::*;

    t_cfg             r_cfg;
    logic             r_in_valid;
    logic             r_in_op;
    logic [DUR_W-1:0] r_in_duration_ms;
    logic             r_out_valid;
    logic [LETTER_W-1:0] r_out_letter;
    logic             w_advance;
    t_result          w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_min_ms      <= PULSE_MIN_RST;
            r_cfg.dot_dash_split_ms <= SPLIT_RST;
            r_cfg.pulse_max_ms      <= PULSE_MAX_RST;
            r_cfg.letter_gap_ms     <= LETTER_GAP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_IDX_PULSE_MIN:  r_cfg.pulse_min_ms      <= i_cfg_data;
                CFG_IDX_SPLIT:      r_cfg.dot_dash_split_ms <= i_cfg_data;
                CFG_IDX_PULSE_MAX:  r_cfg.pulse_max_ms      <= i_cfg_data;
                CFG_IDX_LETTER_GAP: r_cfg.letter_gap_ms     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage moves when the result register is free or being drained
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_op          <= i_op;
            r_in_duration_ms <= i_duration_ms;
        end
    end

    mld_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (r_in_valid && w_advance),
        .i_op          (r_in_op),
        .i_duration_ms (r_in_duration_ms),
        .o_res         (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res.valid) begin
            r_out_letter <= w_res.letter;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_letter    = r_out_letter;

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> r_in_valid && $stable(r_in_duration_ms)
            && $stable(r_in_op))
        else $error("held beat lost from input register");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid && $stable(r_out_letter))
        else $error("stalled letter lost or changed");

    a_letter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_letter >= 7'h41) && (r_out_letter <= 7'h5A))
        else $error("result is not a capital letter");

endmodule

### design/mld_core.sv
// Element classifier, running sum and letter lookup for the Morse decoder.
// Depends on mld_pkg.
module mld_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mld_pkg::t_cfg               i_cfg,
    input  logic                        i_valid,
    input  logic                        i_op,
    input  logic [mld_pkg::DUR_W-1:0]   i_duration_ms,
    output mld_pkg::t_result            o_res
);
    import mld_pkg::*;

    logic [SUM_W-1:0] r_sum, n_sum;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_first_dot, n_first_dot;

    logic             w_is_dot, w_is_dash, w_add, w_end;
    logic [3:0]       w_weight;
    logic [7:0]       w_prod;
    logic [SUM_W:0]   w_sum_ext;
    logic [LETTER_W-1:0] w_letter;

    assign w_is_dot  = (i_duration_ms > i_cfg.pulse_min_ms) &&
                       (i_duration_ms < i_cfg.dot_dash_split_ms);
    assign w_is_dash = !w_is_dot && (i_duration_ms > i_cfg.dot_dash_split_ms) &&
                       (i_duration_ms < i_cfg.pulse_max_ms);
    assign w_add     = i_valid && (i_op == OP_PRESS) && (w_is_dot || w_is_dash);
    assign w_end     = i_valid && (i_op == OP_IDLE) && (i_duration_ms > i_cfg.letter_gap_ms);

    assign w_weight  = w_is_dot ? DOT_WEIGHT : DASH_WEIGHT;
    assign w_prod    = {4'b0000, w_weight} * {4'b0000, r_pos};
    assign w_sum_ext = {1'b0, r_sum} + {3'b000, w_prod};
    assign w_letter  = lookup_letter(r_sum, r_first_dot);

    always_comb begin
        n_sum       = r_sum;
        n_pos       = r_pos;
        n_first_dot = r_first_dot;
        if (w_add) begin
            if (r_pos == 4'd1) begin
                n_first_dot = w_is_dot;
            end
            n_sum = w_sum_ext[SUM_W] ? SUM_MAX : w_sum_ext[SUM_W-1:0];
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + 4'd1;
            end
        end else if (w_end) begin
            n_sum = '0;
            n_pos = 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_pos       <= 4'd1;
            r_first_dot <= 1'b1;
        end else begin
            r_sum       <= n_sum;
            r_pos       <= n_pos;
            r_first_dot <= n_first_dot;
        end
    end

    assign o_res.valid  = w_end && (w_letter != LETTER_NONE);
    assign o_res.letter = w_letter;

    a_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos != '0) else $error("element position reached zero");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end |=> (r_sum == '0) && (r_pos == 4'd1))
        else $error("letter end did not clear sum and position");

    a_result_on_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> i_valid && (i_op == OP_IDLE))
        else $error("letter produced without an idle beat");

    a_sum_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_add && (r_sum != SUM_MAX)) |=> (r_sum > $past(r_sum)))
        else $error("element did not grow the sum");

endmodule

### bench/morse_letter_decoder_top_test.sv
// Self-checking bench for morse_letter_decoder_top: directed and random key timing,
// register settings between drained phases, letters checked against a local model.
// Depends on mld_pkg and morse_letter_decoder_top.
`timescale 1ns / 1ps

module morse_letter_decoder_top_test;
    import mld_pkg::*;

    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SEG_BEATS = 140;
    localparam int NUM_SEGS = 12;

    typedef enum logic [1:0] {CMD_BEAT, CMD_CFG, CMD_DRAIN, CMD_MODE} t_cmd_kind;

    typedef struct {
        t_cmd_kind             kind;
        logic                  op;
        logic [DUR_W-1:0]      dur;
        logic [CFG_IDX_W-1:0]  idx;
        logic [DUR_W-1:0]      data;
        int                    send_pct;
        int                    recv_pct;
    } t_cmd;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_op = OP_PRESS;
    logic [DUR_W-1:0]      i_duration_ms = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [LETTER_W-1:0]   o_letter;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [DUR_W-1:0]      i_cfg_data = '0;

    morse_letter_decoder_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_duration_ms (i_duration_ms),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_letter      (o_letter),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_cmd                 pending[$];
    logic [LETTER_W-1:0]  letters_due[$];
    int                   err_count = 0;
    int                   cycles = 0;
    int                   quiet_cycles = 0;
    int                   send_pct = 0;
    int                   recv_pct = 0;
    int                   beats_queued = 0;

    // decoder model: registers and letter state
    logic [DUR_W-1:0] reg_min = PULSE_MIN_RST;
    logic [DUR_W-1:0] reg_split = SPLIT_RST;
    logic [DUR_W-1:0] reg_max = PULSE_MAX_RST;
    logic [DUR_W-1:0] reg_gap = LETTER_GAP_RST;
    int               sum_acc = 0;
    int               elem_pos = 1;
    bit               lead_dot = 1'b1;

    // registers as the stimulus generator expects them to be when its beats arrive
    int gen_min = int'(PULSE_MIN_RST);
    int gen_split = int'(SPLIT_RST);
    int gen_max = int'(PULSE_MAX_RST);
    int gen_gap = int'(LETTER_GAP_RST);

    function automatic logic [LETTER_W-1:0] letter_for_sum(input int sum, input bit dot_first);
        byte ch;
        case (sum)
            3:       ch = "E";
            9:       ch = "I";
            10:      ch = "T";
            16:      ch = "N";
            18:      ch = "S";
            23:      ch = "A";
            25:      ch = "D";
            30:      ch = dot_first ? "H" : "M";
            32:      ch = "R";
            37:      ch = "B";
            39:      ch = dot_first ? "U" : "G";
            44:      ch = "L";
            46:      ch = "K";
            51:      ch = dot_first ? "F" : "Z";
            53:      ch = "W";
            58:      ch = dot_first ? "V" : "C";
            60:      ch = "O";
            65:      ch = dot_first ? "P" : "X";
            79:      ch = "Q";
            86:      ch = "Y";
            93:      ch = "J";
            default: ch = 8'd0;
        endcase
        return ch[LETTER_W-1:0];
    endfunction

    task automatic fold_beat(input logic op, input logic [DUR_W-1:0] d);
        int               weight;
        int               s;
        bit               is_dot;
        bit               hit;
        logic [LETTER_W-1:0] ch;
        weight = 0;
        is_dot = 1'b0;
        hit = 1'b0;
        if (op == OP_PRESS) begin
            // dot window is tested first; equal to a bound falls in neither
            if (d > reg_min && d < reg_split) begin
                weight = int'(DOT_WEIGHT);
                is_dot = 1'b1;
                hit = 1'b1;
            end else if (d > reg_split && d < reg_max) begin
                weight = int'(DASH_WEIGHT);
                hit = 1'b1;
            end
            if (hit) begin
                if (elem_pos == 1)
                    lead_dot = is_dot;
                s = sum_acc + weight * elem_pos;
                sum_acc = (s > int'(SUM_MAX)) ? int'(SUM_MAX) : s;
                if (elem_pos < int'(POS_MAX))
                    elem_pos++;
            end
        end else if (d > reg_gap) begin
            ch = letter_for_sum(sum_acc, lead_dot);
            sum_acc = 0;
            elem_pos = 1;
            if (ch != LETTER_NONE)
                letters_due.push_back(ch);
        end
    endtask

    task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] v);
        case (idx)
            CFG_IDX_PULSE_MIN:  reg_min = v;
            CFG_IDX_SPLIT:      reg_split = v;
            CFG_IDX_PULSE_MAX:  reg_max = v;
            CFG_IDX_LETTER_GAP: reg_gap = v;
            default: ;
        endcase
    endtask

    // driver: one beat or one register write in flight at a time
    always @(posedge i_clk) begin : drive
        logic in_busy;
        logic cfg_busy;
        logic load_beat;
        logic load_cfg;
        t_cmd head;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_op <= OP_PRESS;
            i_duration_ms <= '0;
            i_cfg_valid <= 1'b0;
            i_cfg_index <= '0;
            i_cfg_data <= '0;
        end else begin
            in_busy = i_in_valid;
            cfg_busy = i_cfg_valid;
            load_beat = 1'b0;
            load_cfg = 1'b0;
            if (in_busy && !o_in_stall) begin
                fold_beat(i_op, i_duration_ms);
                in_busy = 1'b0;
            end
            if (cfg_busy && o_cfg_ready) begin
                apply_reg_write(i_cfg_index, i_cfg_data);
                cfg_busy = 1'b0;
            end
            if (!in_busy && !cfg_busy && pending.size() != 0) begin
                head = pending[0];
                case (head.kind)
                    CMD_BEAT: begin
                        if ($urandom_range(99) >= send_pct) begin
                            load_beat = 1'b1;
                            void'(pending.pop_front());
                        end
                    end
                    CMD_CFG: begin
                        load_cfg = 1'b1;
                        void'(pending.pop_front());
                    end
                    CMD_DRAIN: begin
                        // hold off until every letter is out, then let the pipe empty
                        if (letters_due.size() == 0)
                            quiet_cycles++;
                        else
                            quiet_cycles = 0;
                        if (quiet_cycles >= SETTLE_CYCLES) begin
                            quiet_cycles = 0;
                            void'(pending.pop_front());
                        end
                    end
                    CMD_MODE: begin
                        send_pct <= head.send_pct;
                        recv_pct <= head.recv_pct;
                        void'(pending.pop_front());
                    end
                    default: ;
                endcase
            end
            i_in_valid <= in_busy || load_beat;
            i_cfg_valid <= cfg_busy || load_cfg;
            if (load_beat) begin
                i_op <= head.op;
                i_duration_ms <= head.dur;
            end
            if (load_cfg) begin
                i_cfg_index <= head.idx;
                i_cfg_data <= head.data;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= ($urandom_range(99) < recv_pct);
    end

    // monitor
    always @(posedge i_clk) begin : watch
        logic [LETTER_W-1:0] want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (letters_due.size() == 0) begin
                $error("letter: expected none actual %0d", o_letter);
                err_count++;
            end else begin
                want = letters_due.pop_front();
                if (o_letter !== want) begin
                    $error("letter: expected %0d actual %0d", want, o_letter);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int pick_between(input int lo, input int hi);
        if (hi > lo + 1)
            return $urandom_range(hi - 1, lo + 1);
        return $urandom_range(65535, 0);
    endfunction

    task automatic push_beat(input logic op, input int dur);
        t_cmd c;
        c.kind = CMD_BEAT;
        c.op = op;
        c.dur = dur[DUR_W-1:0];
        c.idx = '0;
        c.data = '0;
        c.send_pct = 0;
        c.recv_pct = 0;
        pending.push_back(c);
        beats_queued++;
    endtask

    task automatic push_ctl(input t_cmd_kind kind, input logic [CFG_IDX_W-1:0] idx,
                            input int data, input int s_pct, input int r_pct);
        t_cmd c;
        c.kind = kind;
        c.op = OP_PRESS;
        c.dur = '0;
        c.idx = idx;
        c.data = data[DUR_W-1:0];
        c.send_pct = s_pct;
        c.recv_pct = r_pct;
        pending.push_back(c);
        if (kind == CMD_CFG) begin
            case (idx)
                CFG_IDX_PULSE_MIN:  gen_min = data & 16'hFFFF;
                CFG_IDX_SPLIT:      gen_split = data & 16'hFFFF;
                CFG_IDX_PULSE_MAX:  gen_max = data & 16'hFFFF;
                CFG_IDX_LETTER_GAP: gen_gap = data & 16'hFFFF;
                default: ;
            endcase
        end
    endtask

    task automatic push_regs(input int pmin, input int split, input int pmax, input int gap);
        push_ctl(CMD_CFG, CFG_IDX_PULSE_MIN, pmin, 0, 0);
        push_ctl(CMD_CFG, CFG_IDX_SPLIT, split, 0, 0);
        push_ctl(CMD_CFG, CFG_IDX_PULSE_MAX, pmax, 0, 0);
        push_ctl(CMD_CFG, CFG_IDX_LETTER_GAP, gap, 0, 0);
    endtask

    // one letter's worth of presses with some noise, closed by a long idle
    task automatic push_letter();
        int n;
        int k;
        int pick;
        if ($urandom_range(39) == 0)
            n = $urandom_range(20, 12);
        else if ($urandom_range(19) == 0)
            n = $urandom_range(6, 0);
        else
            n = $urandom_range(4, 1);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(5) == 0) begin
                pick = $urandom_range(3);
                case (pick)
                    0: push_beat(OP_PRESS, $urandom_range(65535, 0));
                    1: push_beat(OP_PRESS, ($urandom_range(2) == 0) ? gen_min :
                                           ($urandom_range(1) ? gen_split : gen_max));
                    default: push_beat(OP_IDLE, $urandom_range(gen_gap, 0));
                endcase
            end
            if ($urandom_range(1))
                push_beat(OP_PRESS, pick_between(gen_min, gen_split));
            else
                push_beat(OP_PRESS, pick_between(gen_split, gen_max));
        end
        if (gen_gap < 65535)
            push_beat(OP_IDLE, ($urandom_range(3) == 0) ? gen_gap + 1 :
                               $urandom_range(65535, gen_gap + 1));
        else
            push_beat(OP_IDLE, $urandom_range(65535, 0));
    endtask

    initial begin : stim
        int seg;
        int seg_start;
        int a;
        int b;
        int c;
        int k;

        push_ctl(CMD_MODE, '0, 0, 23, 85);

        // directed, at reset register values
        push_beat(OP_PRESS, int'(PULSE_MIN_RST));     // equal to min: ignored
        push_beat(OP_PRESS, PULSE_MIN_RST + 1);      // shortest dot
        push_beat(OP_IDLE, int'(LETTER_GAP_RST));     // not above the gap
        push_beat(OP_IDLE, LETTER_GAP_RST + 1);      // E
        push_beat(OP_IDLE, 65535);                   // empty letter
        push_beat(OP_PRESS, int'(SPLIT_RST));
        push_beat(OP_PRESS, int'(PULSE_MAX_RST));
        push_beat(OP_PRESS, 0);
        push_beat(OP_PRESS, 65535);
        push_beat(OP_PRESS, SPLIT_RST + 1);          // dash
        push_beat(OP_PRESS, PULSE_MAX_RST - 1);      // dash
        push_beat(OP_IDLE, 65535);                   // M shares its sum with H
        for (k = 0; k < 4; k++)
            push_beat(OP_PRESS, SPLIT_RST - 1);
        push_beat(OP_IDLE, 1000);                    // H
        push_beat(OP_PRESS, SPLIT_RST + 1);
        push_beat(OP_PRESS, SPLIT_RST - 1);
        push_beat(OP_PRESS, SPLIT_RST - 1);
        push_beat(OP_PRESS, SPLIT_RST + 1);
        push_beat(OP_IDLE, 0);
        push_beat(OP_IDLE, 5000);                    // P's sum, dash first: X

        for (seg = 0; seg < NUM_SEGS; seg++) begin
            push_ctl(CMD_DRAIN, '0, 0, 0, 0);
            if (seg == 4)
                push_ctl(CMD_MODE, '0, 0, 85, 23);
            else if (seg == 8)
                push_ctl(CMD_MODE, '0, 0, 0, 0);
            case (seg % 6)
                0: push_regs(int'(PULSE_MIN_RST), int'(SPLIT_RST), int'(PULSE_MAX_RST),
                             int'(LETTER_GAP_RST));
                1: begin
                    a = $urandom_range(2000, 1);
                    b = a + $urandom_range(3000, 2);
                    c = b + $urandom_range(3000, 2);
                    push_regs(a, b, c, $urandom_range(5000, 0));
                end
                2: push_regs(0, 2, 4, 0);
                3: push_regs(65535, 65535, 65535, 65535);
                4: push_regs(0, 0, 0, 0);
                default: begin
                    // split below min: dot window empty
                    a = $urandom_range(65535, 1000);
                    push_regs(a, $urandom_range(a - 1, 0), $urandom_range(65535, 0),
                              $urandom_range(65535, 0));
                end
            endcase
            if (seg % 3 == 1)
                push_ctl(CMD_CFG, CFG_IDX_W'($urandom_range(255, 4)),
                         $urandom_range(65535, 0), 0, 0);
            seg_start = beats_queued;
            while (beats_queued - seg_start < ((seg % 6 == 3) ? SEG_BEATS / 4 : SEG_BEATS))
                push_letter();
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || i_in_valid || i_cfg_valid || letters_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES + 4) @(posedge i_clk);

        if (letters_due.size() != 0) begin
            $error("letter: expected %0d actual none", letters_due[0]);
            err_count++;
        end
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
